### rtl/sha_pkg.sv
// Package for the SHA-256 stream hasher: controller states, command/status structs,
// round constants, initial hash values and the SHA-256 helper functions. No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       init_msg;    // restore initial hash, clear length and position
    logic       put_byte;    // write put_val at the current byte position
    logic [7:0] put_val;
    logic       add_len;     // add eight to the bit length
    logic       start_comp;  // copy the hash into the working variables
    logic       do_round;    // run one compression round
    logic       fold;        // add the working variables into the hash
  } dp_cmd_t;

  typedef struct packed {
    logic       block_full;  // byte position wrapped to zero after the last write
    logic [5:0] byte_pos;
    logic       last_round;
    logic [63:0] bit_len;
  } dp_status_t;

  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 64;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] v);
    big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] v);
    big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] v);
    small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] v);
    small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

### rtl/sha_datapath.sv
// Datapath of the SHA-256 stream hasher: hash, working variables, schedule window,
// bit length and byte position. Depends on sha_pkg.
module sha_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sha_pkg::dp_cmd_t    cmd,
  output sha_pkg::dp_status_t status,
  output logic [31:0]         hash_word [8]
);
  import sha_pkg::*;

  logic [31:0] hash_r [8];
  logic [31:0] wv_r   [8];
  logic [31:0] sched_r [16];
  logic [63:0] bit_len_r;
  logic [5:0]  pos_r;
  logic [6:0]  round_r;
  logic        full_r;

  logic [3:0]  t;
  logic [31:0] wt, t1, t2, w_new;

  always_comb begin
    t     = round_r[3:0];
    w_new = small_s1(sched_r[t + 4'd14]) + sched_r[t + 4'd9]
          + small_s0(sched_r[t + 4'd1]) + sched_r[t];
    wt    = (round_r >= 7'd16) ? w_new : sched_r[t];
    t1    = wv_r[7] + big_s1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
          + ROUND_K[round_r[5:0]] + wt;
    t2    = big_s0(wv_r[0]) + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init_msg) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= INIT_HASH[i];
      bit_len_r <= '0;
      pos_r     <= '0;
      full_r    <= 1'b0;
      round_r   <= '0;
    end else begin
      full_r <= 1'b0;
      if (cmd.add_len) bit_len_r <= bit_len_r + 64'd8;
      if (cmd.put_byte) begin
        pos_r  <= pos_r + 6'd1;
        full_r <= (pos_r == 6'd63);
      end
      if (cmd.start_comp) round_r <= '0;
      else if (cmd.do_round) round_r <= round_r + 7'd1;
      if (cmd.fold)
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + wv_r[i];
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      unique case (pos_r[1:0])
        2'd0: sched_r[pos_r[5:2]] <= {cmd.put_val, 24'd0};
        2'd1: sched_r[pos_r[5:2]][23:16] <= cmd.put_val;
        2'd2: sched_r[pos_r[5:2]][15:8]  <= cmd.put_val;
        default: sched_r[pos_r[5:2]][7:0] <= cmd.put_val;
      endcase
    end
    if (cmd.start_comp) begin
      for (int i = 0; i < 8; i++) wv_r[i] <= hash_r[i];
    end else if (cmd.do_round) begin
      sched_r[t] <= wt;
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  assign status.block_full = full_r;
  assign status.byte_pos   = pos_r;
  assign status.last_round = (round_r == 7'(ROUNDS - 1));
  assign status.bit_len    = bit_len_r;
  assign hash_word         = hash_r;

endmodule

### rtl/sha_ctrl.sv
// Controller of the SHA-256 stream hasher: sequences loading, rounds, padding,
// length and digest output. Depends on sha_pkg.
module sha_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_has_byte,
  input  logic                in_end_of_message,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_word_index,
  output logic                out_last_word,
  input  sha_pkg::dp_status_t status,
  output sha_pkg::dp_cmd_t    cmd
);
  import sha_pkg::*;

  ctrl_state_t state_r, state_nxt;
  ctrl_state_t ret_r, ret_nxt;     // where to go after a compression
  logic        end_r, end_nxt;     // message end seen; padding still due
  logic [63:0] len_r, len_nxt;     // length captured at the end
  logic [2:0]  idx_r, idx_nxt;     // length byte or output word counter

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ret_r   <= ST_LOAD;
      end_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      end_r   <= end_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) len_r <= len_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    end_nxt   = end_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = status.block_full;
        if (status.block_full) begin
          cmd.start_comp = 1'b1;
          ret_nxt        = ST_LOAD;
          state_nxt      = ST_ROUND;
        end else if (in_valid) begin
          cmd.put_byte = in_has_byte;
          cmd.put_val  = in_data_byte;
          cmd.add_len  = in_has_byte;
          if (in_end_of_message) begin
            len_nxt   = status.bit_len + (in_has_byte ? 64'd8 : 64'd0);
            state_nxt = ST_PAD;
            end_nxt   = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (status.block_full) begin
          cmd.start_comp = 1'b1;
          ret_nxt        = ST_PAD;
          state_nxt      = ST_ROUND;
        end else begin
          cmd.put_byte = 1'b1;
          cmd.put_val  = end_r ? PAD_BYTE : 8'h00;
          end_nxt      = 1'b0;
          if (status.byte_pos == LEN_POS - 6'd1) begin
            state_nxt = ST_LEN;
            idx_nxt   = '0;
          end
        end
      end
      ST_LEN: begin
        cmd.put_byte = 1'b1;
        cmd.put_val  = len_r[8*(7 - idx_r) +: 8];
        idx_nxt      = idx_r + 3'd1;
        if (idx_r == 3'd7) state_nxt = ST_LEN;
        if (status.block_full) begin
          cmd.put_byte   = 1'b0;
          cmd.start_comp = 1'b1;
          ret_nxt        = ST_EMIT;
          idx_nxt        = '0;
          state_nxt      = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (status.last_round) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ret_r;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.init_msg = 1'b1;
            state_nxt    = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 3'd7);

endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: joins controller and datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
//   Channel | Direction | Payload                                   | Handshake
//   in_     | input     | data_byte[8], has_byte, end_of_message    | in_valid / in_stall
//   out_    | output    | digest_word[32], word_index[3], last_word | out_valid / out_stall
//
// A request is taken while the block is loading; each full 64-byte block is then compressed
// in the shared round unit: a setup step copies the hash, the 64 rounds run, and a fold adds
// the result into the hash. Ending a message adds padding at one byte per cycle except while
// a full block is compressed, one or two more compressions and eight output words. Reset
// (synchronous, active low) loads the initial hash and clears length and position. Input is
// stalled during rounds, padding and output; a stalled output word holds until taken.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] hash_word [8];

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_has_byte, .in_end_of_message,
    .out_valid, .out_stall, .out_word_index, .out_last_word, .status, .cmd
  );

  sha_datapath u_dp (.clk, .rst_n, .cmd, .status, .hash_word);

  // Output word is read straight from the stable hash register.
  assign out_digest_word = hash_word[out_word_index];

endmodule

### rtl/sha_checker.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends only on the top level's ports.
module sha_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_word_index,
  input logic       out_last_word
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word flag disagrees with word index");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=> (out_valid &&
      out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words not in order");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest is shown");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word_index)))
    else $error("stalled output changed");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_word_index, .out_last_word
);

### tb/sha_digest_checker.sv
// Checker for the SHA-256 stream hasher: watches both channels, predicts digests
// with its own SHA-256 model and compares them. Depends on nothing but the ports.
`timescale 1ns / 1ps

module sha_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]  hash_acc [8];
  logic [7:0]   block_buf [64];
  logic [5:0]   fill_pos;
  logic [63:0]  msg_bits;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror32(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  task automatic compress_buffer();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int j = 0; j < 8; j++) v[j] = hash_acc[j];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KC[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_acc[j] += v[j];
  endtask

  task automatic append_byte(logic [7:0] b);
    block_buf[fill_pos] = b;
    fill_pos++;
    if (fill_pos == 0) compress_buffer();
  endtask

  task automatic start_message();
    for (int j = 0; j < 8; j++) hash_acc[j] = IV[j];
    fill_pos = 0;
    msg_bits = 0;
  endtask

  task automatic absorb_request(logic [7:0] b, logic has, logic fin);
    logic [63:0] len;
    if (has) begin
      append_byte(b);
      msg_bits += 64'd8;
    end
    if (fin) begin
      len = msg_bits;
      append_byte(8'h80);
      while (fill_pos != 6'd56) append_byte(8'h00);
      for (int i = 7; i >= 0; i--) append_byte(len[8*i +: 8]);
      for (int i = 0; i < 8; i++) digest_q.push_back('{hash_acc[i], 3'(i), i == 7});
      start_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    words_pending = 0;
    start_message();
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        absorb_request(in_data_byte, in_has_byte, in_end_of_message);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected word", out_digest_word, 32'h0);
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word)
            report_mismatch("digest_word", out_digest_word, want.word);
          if (out_word_index !== want.index)
            report_mismatch("word_index", 32'(out_word_index), 32'(want.index));
          if (out_last_word !== want.last)
            report_mismatch("last_word", 32'(out_last_word), 32'(want.last));
        end
      end
    end
    words_pending = digest_q.size();
  end

endmodule

### tb/tb_top.sv
// Top of the SHA-256 stream hasher testbench: clock, reset, request stimulus and
// verdict. Depends on sha256_stream_hasher and sha_digest_checker.
`timescale 1ns / 1ps

module tb_top;

  // Slowest correct run: a request may wait through a two-block finish plus eight words,
  // each stalled for a random time by the receiver; IDLE_LIMIT leaves ample margin.
  localparam int IDLE_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          words_pending;
  int          idle_cycles;
  bit          hold_output;

  sha256_stream_hasher uut (.*);

  sha_digest_checker checker_i (.*);

  // The clock runs at a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Send one request and keep it steady until the block takes it. The valid goes low
  // only when a random gap follows, so back-to-back requests keep it high.
  task automatic send_request(logic [7:0] b, logic has, logic fin);
    int gap;
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_has_byte       <= has;
    in_end_of_message <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // A message of len bytes, random or the fill byte; the end flag rides on the last
  // byte or, half the time and always when len is 0, on a separate empty request.
  task automatic send_message(int len, bit random_fill, logic [7:0] fill);
    bit split_end;
    split_end = (len == 0) || $urandom_range(0, 1);
    for (int i = 0; i < len; i++)
      send_request(random_fill ? 8'($urandom) : fill, 1'b1,
                   !split_end && (i == len - 1));
    if (split_end) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // The receiver draws a fresh stall length for every word. While the long hold is on,
  // it stalls outright so that the block fills up and pushes back on the input side.
  initial begin
    int wait_cycles;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
      end else begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
        out_stall <= 1'b0;
        do @(posedge clk); while (!(out_valid && !out_stall));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    idle_cycles       = 0;
    hold_output       = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'h00;
    in_has_byte       = 1'b0;
    in_end_of_message = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: the empty message, ignored requests, extreme byte values, the
    // byte carried with the end flag, and short messages.
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h55, 1'b1, 1'b1);
    send_message(3, 1'b1, 8'h00);

    // Long hold on the output while messages keep coming: digests back up and the
    // input side has to stall.
    hold_output = 1'b1;
    fork
      begin
        send_message(2, 1'b1, 8'h00);
        send_message(1, 1'b1, 8'h00);
      end
      begin
        repeat (300) @(negedge clk);
        hold_output = 1'b0;
      end
    join

    // Random part: short messages, one full 64-byte block followed by a padding
    // block, and stray idle requests.
    for (int m = 0; m < 12; m++) begin
      int len;
      len = (m == 5) ? 64 : $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_message(len, 1'b1, 8'h00);
    end
    in_valid <= 1'b0;

    while (words_pending > 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
